// ===== src/assert_macros.svh =====
// Assertion macros used by the servo pulse generator RTL.
// No dependencies; guarded against repeated inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define MSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSP_ASSERT(label, clk, rst, prop, msg)
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/msp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the servo pulse generator.
// No dependencies.
package msp_pkg;

   localparam int CHANNELS   = 8;
   localparam int CH_IDX_W   = $clog2(CHANNELS);
   localparam int CNT_W      = $clog2(CHANNELS + 1);
   localparam int CH_FIELD_W = 3;
   localparam int WIDTH_W    = 16;
   localparam int PIN_W      = 8;
   localparam int COUNT_W    = 4;
   localparam int REQ_W      = 2;

   localparam logic [WIDTH_W-1:0] PERIOD_RESET = WIDTH_W'(20000);

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_ATTACH = 2'd1,
      REQ_SET    = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [REQ_W-1:0]      req_type;
      logic [CH_FIELD_W-1:0] channel;
      logic [WIDTH_W-1:0]    pulse_width;
      logic [WIDTH_W-1:0]    min_width;
      logic [WIDTH_W-1:0]    max_width;
   } req_beat_type;

   typedef struct packed {
      logic [PIN_W-1:0]   pin_levels;
      logic               accepted;
      logic [COUNT_W-1:0] attached_count;
   } rsp_beat_type;

   // Zero width behaves as one tick.
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
      eff_width = (w == '0) ? WIDTH_W'(1) : w;
   endfunction

   // Raise to the lower limit, then cap at the upper limit.
   function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v,
                                                       input logic [WIDTH_W-1:0] lo,
                                                       input logic [WIDTH_W-1:0] hi);
      logic [WIDTH_W-1:0] r;
      r = (v < lo) ? lo : v;
      clamp_width = (r > hi) ? hi : r;
   endfunction

   // One bit per attached slot.
   function automatic logic [CHANNELS-1:0] member_mask(input logic [CNT_W-1:0] cnt);
      logic [CHANNELS-1:0] m;
      m = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         m[i] = (CNT_W'(i) < cnt);
      end
      member_mask = m;
   endfunction

endpackage

// ===== src/multichannel_servo_pulse_generator.sv =====
`timescale 1ns / 1ps
// Top level of the multichannel servo pulse generator.
// Depends on msp_pkg, msp_in_stage, msp_engine and msp_out_stage.
//
//  channel | direction | handshake         | beat contents
//  req     | in        | req_valid/stall   | request type, channel, width, limits
//  rsp     | out       | rsp_valid/stall   | pin levels, accepted flag, attached count
//  csr     | in        | csr_valid/ready   | frame period in microsecond ticks
//
// One request beat per clock unless stalled: the input register feeds the channel
// table and per-channel width compares, whose result lands in the result register.
// A request passes the input register, then the result register, before rsp_valid.
// Synchronous active-high reset clears count, timer, pins and the run flag;
// the frame period returns to 20000 ticks. csr_ready is always high.
// rsp_stall holds the result register and, through it, the input register.
module multichannel_servo_pulse_generator (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msp_pkg::REQ_W-1:0]           req_type,
   input  logic [msp_pkg::CH_FIELD_W-1:0]      req_channel,
   input  logic [msp_pkg::WIDTH_W-1:0]         req_pulse_width,
   input  logic [msp_pkg::WIDTH_W-1:0]         req_min_width,
   input  logic [msp_pkg::WIDTH_W-1:0]         req_max_width,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [msp_pkg::PIN_W-1:0]           rsp_pin_levels,
   output logic                                rsp_accepted,
   output logic [msp_pkg::COUNT_W-1:0]         rsp_attached_count,
   // frame period register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msp_pkg::WIDTH_W-1:0]         csr_wdata
);

   msp_pkg::req_beat_type req_beat;
   msp_pkg::req_beat_type hold_beat;
   msp_pkg::rsp_beat_type result;
   msp_pkg::rsp_beat_type rsp_beat;
   logic                  hold_valid;
   logic                  out_free;
   logic                  fire;

   // Pack the request fields into one beat.
   assign req_beat.req_type    = req_type;
   assign req_beat.channel     = req_channel;
   assign req_beat.pulse_width = req_pulse_width;
   assign req_beat.min_width   = req_min_width;
   assign req_beat.max_width   = req_max_width;

   // The held request is processed whenever the result register can take it.
   assign fire = hold_valid && out_free;

   // Writes must be issued only while idle (the block does not enforce it); the port never pushes back.
   assign csr_ready = 1'b1;

   msp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_beat   (req_beat),
      .req_stall  (req_stall),
      .advance    (out_free),
      .hold_valid (hold_valid),
      .hold_beat  (hold_beat)
   );

   msp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .beat      (hold_beat),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   msp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   // Unpack the result beat onto the response ports.
   assign rsp_pin_levels     = rsp_beat.pin_levels;
   assign rsp_accepted       = rsp_beat.accepted;
   assign rsp_attached_count = rsp_beat.attached_count;

endmodule

// ===== src/msp_in_stage.sv =====
`timescale 1ns / 1ps
// Input register for request beats.
// Depends on msp_pkg.
module msp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  msp_pkg::req_beat_type req_beat,
   output logic                 req_stall,
   input  logic                 advance,
   output logic                 hold_valid,
   output msp_pkg::req_beat_type hold_beat
);

   logic                  valid_ff, valid_in;
   msp_pkg::req_beat_type beat_ff, beat_in;
   logic                  take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (!valid_ff || advance) begin
         valid_in = req_valid;
      end
      if (take) begin
         beat_in = req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign hold_valid = valid_ff;
   assign hold_beat  = beat_ff;

endmodule

// ===== src/msp_engine.sv =====
`timescale 1ns / 1ps
// Channel table, frame timer and pin state; computes one result per beat.
// Depends on msp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module msp_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  msp_pkg::req_beat_type                beat,
   input  logic                                 csr_we,
   input  logic [msp_pkg::WIDTH_W-1:0]          csr_wdata,
   output msp_pkg::rsp_beat_type                result
);

   localparam int CH = msp_pkg::CHANNELS;
   localparam int WW = msp_pkg::WIDTH_W;
   localparam int CW = msp_pkg::CNT_W;

   logic [WW-1:0] set_w_ff   [CH];
   logic [WW-1:0] set_w_in   [CH];
   logic [WW-1:0] lo_ff      [CH];
   logic [WW-1:0] hi_ff      [CH];
   logic [WW-1:0] frame_w_ff [CH];
   logic [WW-1:0] frame_w_in [CH];

   logic [CW-1:0] count_ff, count_in;
   logic [WW-1:0] frame_time_ff, frame_time_in;
   logic [CH-1:0] pin_ff, pin_in;
   logic          running_ff, running_in;
   logic [WW-1:0] period_ff;

   logic                          acc;
   logic                          snap;
   logic                          attach_ok;
   logic                          write_lim;
   logic [WW:0]                   t_next;
   logic [msp_pkg::CH_IDX_W-1:0]  slot;
   logic [msp_pkg::CH_IDX_W-1:0]  sel;
   logic [WW-1:0]                 new_w;
   msp_pkg::req_code_type         code;

   assign code      = msp_pkg::req_code_type'(beat.req_type);
   assign slot      = count_ff[msp_pkg::CH_IDX_W-1:0];
   assign sel       = msp_pkg::CH_IDX_W'(beat.channel);
   assign t_next    = {1'b0, frame_time_ff} + (WW+1)'(1);
   assign attach_ok = count_ff < CW'(CH);
   assign write_lim = fire && (code == msp_pkg::REQ_ATTACH) && attach_ok;

   always_comb begin
      count_in      = count_ff;
      frame_time_in = frame_time_ff;
      pin_in        = pin_ff;
      running_in    = running_ff;
      acc           = 1'b0;
      snap          = 1'b0;
      new_w         = '0;
      for (int i = 0; i < CH; i++) begin
         set_w_in[i]   = set_w_ff[i];
         frame_w_in[i] = frame_w_ff[i];
      end

      unique case (code)
         msp_pkg::REQ_TICK: begin
            acc = 1'b1;
            if (running_ff) begin
               for (int i = 0; i < CH; i++) begin
                  if (t_next >= {1'b0, msp_pkg::eff_width(frame_w_ff[i])}) begin
                     pin_in[i] = 1'b0;
                  end
               end
               // All pins already low means the frame passed its last fall.
               if (t_next >= {1'b0, period_ff} && pin_ff == '0) begin
                  snap = 1'b1;
               end else begin
                  frame_time_in = t_next[WW-1:0];
               end
            end
         end
         msp_pkg::REQ_ATTACH: begin
            if (attach_ok) begin
               new_w          = msp_pkg::clamp_width(beat.pulse_width, beat.min_width,
                                                     beat.max_width);
               set_w_in[slot] = new_w;
               count_in       = count_ff + CW'(1);
               acc            = 1'b1;
               if (!running_ff) begin
                  running_in = 1'b1;
                  snap       = 1'b1;
               end
            end
         end
         msp_pkg::REQ_SET: begin
            if (CW'(beat.channel) < count_ff) begin
               new_w         = msp_pkg::clamp_width(beat.pulse_width, lo_ff[sel], hi_ff[sel]);
               set_w_in[sel] = new_w;
               acc           = 1'b1;
            end
         end
         default: begin
            acc = 1'b0;
         end
      endcase

      if (snap) begin
         pin_in        = msp_pkg::member_mask(count_in);
         frame_time_in = '0;
         for (int i = 0; i < CH; i++) begin
            frame_w_in[i] = set_w_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         frame_time_ff <= '0;
         pin_ff        <= '0;
         running_ff    <= 1'b0;
         period_ff     <= msp_pkg::PERIOD_RESET;
      end else begin
         if (fire) begin
            count_ff      <= count_in;
            frame_time_ff <= frame_time_in;
            pin_ff        <= pin_in;
            running_ff    <= running_in;
         end
         if (csr_we) begin
            period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < CH; i++) begin
            set_w_ff[i]   <= set_w_in[i];
            frame_w_ff[i] <= frame_w_in[i];
         end
      end
      if (write_lim) begin
         lo_ff[slot] <= beat.min_width;
         hi_ff[slot] <= beat.max_width;
      end
   end

   assign result.pin_levels     = msp_pkg::PIN_W'(pin_in);
   assign result.accepted       = acc;
   assign result.attached_count = msp_pkg::COUNT_W'(count_in);

   `MSP_ASSERT(a_idle_quiet, clock, reset, !running_ff |-> (pin_ff == '0 && frame_time_ff == '0), "pins or timer active while stopped")
   `MSP_ASSERT(a_run_needs_chan, clock, reset, running_ff |-> (count_ff != '0), "running with no channel attached")
   `MSP_ASSERT(a_pins_attached, clock, reset, (pin_ff & ~msp_pkg::member_mask(count_ff)) == '0, "pin high on unattached slot")
   `MSP_ASSERT_NEXT(a_attach_counts, clock, reset, write_lim, count_ff == $past(count_ff) + CW'(1), "attach did not advance count")

endmodule

// ===== src/msp_out_stage.sv =====
`timescale 1ns / 1ps
// Result register holding one response beat until it is taken.
// Depends on msp_pkg.
module msp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  msp_pkg::rsp_beat_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msp_pkg::rsp_beat_type rsp_beat
);

   logic                  valid_ff, valid_in;
   msp_pkg::rsp_beat_type beat_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (fire) begin
         beat_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

// ===== test/msp_servo_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the servo pulse generator: predicts every response beat
// from accepted request beats and period writes, then compares. Needs msp_pkg.
module msp_servo_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [msp_pkg::REQ_W-1:0]      req_type,
   input  logic [msp_pkg::CH_FIELD_W-1:0] req_channel,
   input  logic [msp_pkg::WIDTH_W-1:0]    req_pulse_width,
   input  logic [msp_pkg::WIDTH_W-1:0]    req_min_width,
   input  logic [msp_pkg::WIDTH_W-1:0]    req_max_width,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [msp_pkg::PIN_W-1:0]      rsp_pin_levels,
   input  logic                           rsp_accepted,
   input  logic [msp_pkg::COUNT_W-1:0]    rsp_attached_count,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [msp_pkg::WIDTH_W-1:0]    csr_wdata,
   output int                             failures,
   output int                             beats_checked,
   output int                             outstanding
);

   localparam int SHOWN_LIMIT = 50;

   logic [msp_pkg::WIDTH_W-1:0] period_us;
   logic [msp_pkg::COUNT_W-1:0] slots_used;
   logic [msp_pkg::COUNT_W-1:0] frame_slots;
   logic [msp_pkg::WIDTH_W-1:0] slot_width [msp_pkg::CHANNELS];
   logic [msp_pkg::WIDTH_W-1:0] slot_lo [msp_pkg::CHANNELS];
   logic [msp_pkg::WIDTH_W-1:0] slot_hi [msp_pkg::CHANNELS];
   logic [msp_pkg::WIDTH_W-1:0] frame_width [msp_pkg::CHANNELS];
   logic [msp_pkg::WIDTH_W-1:0] frame_ticks;
   logic [msp_pkg::PIN_W-1:0]   pins;
   logic                        frame_live;
   msp_pkg::rsp_beat_type       due_levels [$];
   msp_pkg::req_beat_type       taken;
   msp_pkg::rsp_beat_type       want;

   initial begin
      failures      = 0;
      beats_checked = 0;
      outstanding   = 0;
   end

   task automatic flag_mismatch(input string msg);
      if (failures < SHOWN_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      failures++;
   endtask

   // Tick on which a pin falls; zero width still gives one tick.
   function automatic logic [msp_pkg::WIDTH_W:0] fall_tick(
      input logic [msp_pkg::WIDTH_W-1:0] w);
      return (w == '0) ? (msp_pkg::WIDTH_W+1)'(1) : {1'b0, w};
   endfunction

   // Lower limit first, upper limit wins when the two cross.
   function automatic logic [msp_pkg::WIDTH_W-1:0] limit_width(
      input logic [msp_pkg::WIDTH_W-1:0] v,
      input logic [msp_pkg::WIDTH_W-1:0] lo,
      input logic [msp_pkg::WIDTH_W-1:0] hi);
      logic [msp_pkg::WIDTH_W-1:0] r;
      r = (v < lo) ? lo : v;
      return (r > hi) ? hi : r;
   endfunction

   function automatic void open_frame();
      frame_slots = slots_used;
      pins = '0;
      for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
         if (i < slots_used) begin
            frame_width[i] = slot_width[i];
            pins[i] = 1'b1;
         end
      end
      frame_ticks = '0;
   endfunction

   function automatic msp_pkg::rsp_beat_type serve_request(input msp_pkg::req_beat_type r);
      msp_pkg::rsp_beat_type     o;
      logic [msp_pkg::WIDTH_W:0] t;
      logic [msp_pkg::WIDTH_W:0] last;
      logic [msp_pkg::WIDTH_W:0] frame_stop;
      logic                      took;
      took = 1'b0;
      case (r.req_type)
         msp_pkg::REQ_TICK: begin
            took = 1'b1;
            if (frame_live) begin
               t = {1'b0, frame_ticks} + 1'b1;
               last = '0;
               for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
                  if (i < frame_slots) begin
                     if (t >= fall_tick(frame_width[i])) pins[i] = 1'b0;
                     if (fall_tick(frame_width[i]) > last) last = fall_tick(frame_width[i]);
                  end
               end
               // frame never shorter than one tick past the last fall
               frame_stop = ({1'b0, period_us} > last) ? {1'b0, period_us} : last + 1'b1;
               if (t >= frame_stop) begin
                  open_frame();
               end else begin
                  frame_ticks = t[msp_pkg::WIDTH_W-1:0];
               end
            end
         end
         msp_pkg::REQ_ATTACH: begin
            if (slots_used < msp_pkg::CHANNELS) begin
               slot_lo[slots_used[msp_pkg::CH_IDX_W-1:0]] = r.min_width;
               slot_hi[slots_used[msp_pkg::CH_IDX_W-1:0]] = r.max_width;
               slot_width[slots_used[msp_pkg::CH_IDX_W-1:0]] =
                  limit_width(r.pulse_width, r.min_width, r.max_width);
               slots_used = slots_used + 1'b1;
               took = 1'b1;
               if (!frame_live) begin
                  frame_live = 1'b1;
                  open_frame();
               end
            end
         end
         msp_pkg::REQ_SET: begin
            if (r.channel < slots_used) begin
               slot_width[r.channel] =
                  limit_width(r.pulse_width, slot_lo[r.channel], slot_hi[r.channel]);
               took = 1'b1;
            end
         end
         default: ;
      endcase
      o.pin_levels     = pins;
      o.accepted       = took;
      o.attached_count = slots_used;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         period_us   = msp_pkg::PERIOD_RESET;
         slots_used  = '0;
         frame_slots = '0;
         frame_ticks = '0;
         pins        = '0;
         frame_live  = 1'b0;
         due_levels.delete();
      end else begin
         if (csr_valid && csr_ready) period_us = csr_wdata;
         if (req_valid && !req_stall) begin
            taken.req_type    = req_type;
            taken.channel     = req_channel;
            taken.pulse_width = req_pulse_width;
            taken.min_width   = req_min_width;
            taken.max_width   = req_max_width;
            due_levels.push_back(serve_request(taken));
         end
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (due_levels.size() == 0) begin
               flag_mismatch("response beat with nothing expected");
            end else begin
               want = due_levels.pop_front();
               if (rsp_pin_levels !== want.pin_levels)
                  flag_mismatch($sformatf("pin_levels %b, expected %b",
                                          rsp_pin_levels, want.pin_levels));
               if (rsp_accepted !== want.accepted)
                  flag_mismatch($sformatf("accepted %b, expected %b",
                                          rsp_accepted, want.accepted));
               if (rsp_attached_count !== want.attached_count)
                  flag_mismatch($sformatf("attached_count %0d, expected %0d",
                                          rsp_attached_count, want.attached_count));
            end
         end
      end
      outstanding <= due_levels.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the servo pulse generator: clock, reset, request and frame
// period stimulus, verdict. Needs msp_pkg, msp_servo_checker and the block itself.
module tb;

   // request code with no meaning; the block must refuse it
   localparam logic [msp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int IDLE_LIMIT   = 2000;   // cycles without any beat before giving up
   localparam int DRAIN_CYCLES = 8;      // extra wait once nothing is due, for slack
   localparam int RANDOM_BEATS = 1600;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [msp_pkg::REQ_W-1:0]      req_type = '0;
   logic [msp_pkg::CH_FIELD_W-1:0] req_channel = '0;
   logic [msp_pkg::WIDTH_W-1:0]    req_pulse_width = '0;
   logic [msp_pkg::WIDTH_W-1:0]    req_min_width = '0;
   logic [msp_pkg::WIDTH_W-1:0]    req_max_width = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [msp_pkg::PIN_W-1:0]      rsp_pin_levels;
   logic                           rsp_accepted;
   logic [msp_pkg::COUNT_W-1:0]    rsp_attached_count;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [msp_pkg::WIDTH_W-1:0]    csr_wdata = '0;

   int failures;
   int beats_checked;
   int outstanding;
   int attaches_sent   = 0;
   int beats_sent      = 0;
   int random_sent     = 0;
   int period_settings = 0;
   int hold_left       = 0;
   int idle_cycles     = 0;
   bit eager           = 1'b0;   // no sender gaps for the whole phase

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   multichannel_servo_pulse_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_channel        (req_channel),
      .req_pulse_width    (req_pulse_width),
      .req_min_width      (req_min_width),
      .req_max_width      (req_max_width),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pin_levels     (rsp_pin_levels),
      .rsp_accepted       (rsp_accepted),
      .rsp_attached_count (rsp_attached_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   msp_servo_checker chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_channel        (req_channel),
      .req_pulse_width    (req_pulse_width),
      .req_min_width      (req_min_width),
      .req_max_width      (req_max_width),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pin_levels     (rsp_pin_levels),
      .rsp_accepted       (rsp_accepted),
      .rsp_attached_count (rsp_attached_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata),
      .failures           (failures),
      .beats_checked      (beats_checked),
      .outstanding        (outstanding)
   );

   // Receiver back-pressure: alternating open and stalled spells. Mostly short,
   // now and then a long stall, and now and then a long open run with no stall.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b1;
         hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 3);
      end
   end

   // Watchdog: any accepted beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("No beat moved for %0d cycles, %0d responses still due",
                  idle_cycles, outstanding);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic msp_pkg::req_beat_type make_req(
      input logic [msp_pkg::REQ_W-1:0]      kind,
      input logic [msp_pkg::CH_FIELD_W-1:0] ch,
      input logic [msp_pkg::WIDTH_W-1:0]    pw,
      input logic [msp_pkg::WIDTH_W-1:0]    lo,
      input logic [msp_pkg::WIDTH_W-1:0]    hi);
      msp_pkg::req_beat_type b;
      b.req_type    = kind;
      b.channel     = ch;
      b.pulse_width = pw;
      b.min_width   = lo;
      b.max_width   = hi;
      return b;
   endfunction

   // Mostly ticks so frames keep turning over. Attaches while slots remain use
   // small limits, so no channel can ever hold a width above 48 and frames stay
   // short; once full, attaches carry fully random fields and get refused.
   function automatic msp_pkg::req_beat_type random_request();
      msp_pkg::req_beat_type b;
      int                    pick;
      pick          = $urandom_range(0, 99);
      b.channel     = msp_pkg::CH_FIELD_W'($urandom);
      b.pulse_width = msp_pkg::WIDTH_W'($urandom);
      b.min_width   = msp_pkg::WIDTH_W'($urandom);
      b.max_width   = msp_pkg::WIDTH_W'($urandom);
      if (pick < 55) begin
         b.req_type = msp_pkg::REQ_TICK;
      end else if (pick < 65) begin
         b.req_type = msp_pkg::REQ_ATTACH;
         if (attaches_sent < msp_pkg::CHANNELS) begin
            b.min_width = msp_pkg::WIDTH_W'($urandom_range(0, 15));
            b.max_width = msp_pkg::WIDTH_W'($urandom_range(0, 48));
            if ($urandom_range(0, 3) != 0)
               b.pulse_width = msp_pkg::WIDTH_W'($urandom_range(0, 63));
         end
      end else if (pick < 95) begin
         b.req_type = msp_pkg::REQ_SET;
         if ($urandom_range(0, 4) != 0)
            b.pulse_width = msp_pkg::WIDTH_W'($urandom_range(0, 63));
      end else begin
         b.req_type = REQ_UNUSED;
      end
      return b;
   endfunction

   // Present one request beat, hold it until taken, then maybe idle a while.
   // With no gap, valid stays high and the next call just swaps the payload.
   task automatic push_req(input msp_pkg::req_beat_type b);
      int gap;
      req_valid       <= 1'b1;
      req_type        <= b.req_type;
      req_channel     <= b.channel;
      req_pulse_width <= b.pulse_width;
      req_min_width   <= b.min_width;
      req_max_width   <= b.max_width;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (b.req_type == msp_pkg::REQ_ATTACH) attaches_sent++;
      if (eager || $urandom_range(0, 1) == 0) begin
         gap = 0;
      end else if ($urandom_range(0, 4) == 0) begin
         gap = $urandom_range(6, 25);
      end else begin
         gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain: the checker's count is registered, hence the first wait.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [msp_pkg::WIDTH_W-1:0] period);
      csr_valid <= 1'b1;
      csr_wdata <= period;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      period_settings++;
   endtask

   initial begin : stimulus
      int                          phase;
      int                          span;
      logic [msp_pkg::WIDTH_W-1:0] period;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset period of 20000 ticks.
      // Tick before anything is attached: accepted, nothing moves.
      push_req(make_req(msp_pkg::REQ_TICK, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      // set width on an empty slot and an unused code: both refused
      push_req(make_req(msp_pkg::REQ_SET, 3'd3, 16'd7, 16'd0, 16'd0));
      push_req(make_req(REQ_UNUSED, 3'd0, 16'd0, 16'd0, 16'd0));
      // first attach starts the frame; zero width behaves as one tick
      push_req(make_req(msp_pkg::REQ_ATTACH, 3'd0, 16'd0, 16'd0, 16'd40));
      push_req(make_req(msp_pkg::REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0));
      // attaches mid-frame stay low; clamp high, crossed limits, clamp low
      push_req(make_req(msp_pkg::REQ_ATTACH, 3'd0, 16'hFFFF, 16'd0, 16'd25));
      push_req(make_req(msp_pkg::REQ_ATTACH, 3'd0, 16'd3, 16'hFFFF, 16'd18));
      push_req(make_req(msp_pkg::REQ_ATTACH, 3'd0, 16'd2, 16'd9, 16'd30));
      push_req(make_req(msp_pkg::REQ_TICK, 3'd2, 16'h00FF, 16'h0F0F, 16'h3333));
      push_req(make_req(msp_pkg::REQ_SET, 3'd1, 16'hFFFF, 16'd0, 16'd0));
      push_req(make_req(msp_pkg::REQ_SET, 3'd2, 16'd0, 16'd0, 16'd0));
      // upper limit of zero pins the width at zero
      push_req(make_req(msp_pkg::REQ_ATTACH, 3'd0, 16'd21, 16'd0, 16'd0));
      push_req(make_req(msp_pkg::REQ_ATTACH, 3'd0, 16'hAAAA, 16'd4, 16'd48));
      push_req(make_req(msp_pkg::REQ_SET, 3'd7, 16'd5, 16'd0, 16'd0));
      push_req(make_req(msp_pkg::REQ_SET, 3'd5, 16'h5555, 16'd0, 16'd0));
      push_req(make_req(msp_pkg::REQ_TICK, 3'd7, 16'hFFFF, 16'd0, 16'hFFFF));
      push_req(make_req(msp_pkg::REQ_TICK, 3'd1, 16'd0, 16'hFFFF, 16'd0));
      push_req(make_req(REQ_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));

      // Random phases, each under its own frame period. The early ones hit the
      // extremes; 65535 followed by 30 shortens the period well into a frame.
      phase = 0;
      while (random_sent < RANDOM_BEATS) begin
         wait_idle();
         case (phase)
            0:       period = 16'd14;
            1:       period = 16'd0;
            2:       period = 16'd1;
            3:       period = 16'hFFFF;
            4:       period = 16'd30;
            5:       period = 16'd2;
            default: period = msp_pkg::WIDTH_W'($urandom_range(0, 70));
         endcase
         write_period(period);
         eager = ($urandom_range(0, 3) == 0);
         span  = $urandom_range(120, 200);
         repeat (span) begin
            push_req(random_request());
            random_sent++;
         end
         phase++;
      end
      wait_idle();

      $display("Sent %0d request beats (%0d random) under %0d frame periods besides the reset one,",
               beats_sent, random_sent, period_settings);
      $display("%0d attaches tried, %0d response beats compared", attaches_sent, beats_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
